FILE: design/rma_pkg.sv
// ----------------------------------------------------------------------------
// rma_pkg
// Shared constants and request codes for the ring moving-average filter.
// ----------------------------------------------------------------------------
package rma_pkg;

   localparam int DATA_W        = 16;  // sample, average and last-value width
   localparam int CSR_W         = 7;   // window_slots register width
   localparam int MAX_SLOTS_DEF = 64;  // default ring depth
   localparam int WIN_RESET     = 4;   // window_slots after reset
   localparam int TYPE_W        = 2;   // request kind width

   typedef enum logic [TYPE_W-1:0] {
      REQ_RECORD  = 2'd0,
      REQ_RESET   = 2'd1,
      REQ_FLUSH   = 2'd2,
      REQ_RECALC  = 2'd3
   } req_kind_type;

endpackage

FILE: design/rma_alu.sv
// ----------------------------------------------------------------------------
// rma_alu
// Shared add/subtract unit: running total updates, ring sums, negation and
// the trial subtract of the serial divider all pass through it.
// ----------------------------------------------------------------------------
module rma_alu #(
   parameter int WIDTH = 24
) (
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output logic             negative
);

   always_comb begin
      if (sub) begin
         result = opa - opb;
      end else begin
         result = opa + opb;
      end
      negative = result[WIDTH-1];
   end

endmodule

FILE: design/ring_moving_average.sv
// ----------------------------------------------------------------------------
// ring_moving_average
// Boxcar moving-average filter over a ring of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one request word: tuser is the request kind (record, reset
//   fill, flush fill, recalculate), tdata the sample or fill value. rsp_*
//   returns one word per request: average, last recorded slot, sample count.
//   csr_* writes window_slots; write it only while no request is in flight.
// Sequence (n = window size, TW = total width, 24 at 64 slots):
//   record      add sample, subtract old slot, TW-bit divide, output
//   reset/flush write all n window slots, output
//   recalculate read and sum all n window slots, TW-bit divide, output
//   One request is in flight at a time; the single add/subtract unit serves
//   all arithmetic, and the restoring divider yields one bit per cycle.
// Reset:
//   synchronous, active high. Afterwards a clearing pass writes zero to all
//   MAX_SLOTS ring entries, one per cycle; req_tready stays low until it
//   ends. csr writes are taken throughout.
// Stall:
//   a result waits in the output register while rsp_tready is low; the next
//   request is still accepted and computed, and holds before its output load.
// ----------------------------------------------------------------------------
module ring_moving_average #(
   parameter int MAX_SLOTS = rma_pkg::MAX_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rma_pkg::DATA_W-1:0]  req_tdata,  // [15:0] sample_value
   input  logic [rma_pkg::TYPE_W-1:0]  req_tuser,  // [1:0] req_type
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [15:0] average, [31:16] last_value, [38:32] sample_count, [39] zero
   output logic [39:0]                 rsp_tdata,
   // window_slots write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rma_pkg::CSR_W-1:0]   csr_data
);
   import rma_pkg::*;

   localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int NW      = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int TOTAL_W = DATA_W + SLOT_W + 2;
   localparam int AW      = TOTAL_W + 1;
   localparam int BIT_W   = $clog2(TOTAL_W);

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b0000_0000_0001,
      S_IDLE     = 12'b0000_0000_0010,
      S_REC_ADD  = 12'b0000_0000_0100,
      S_REC_SUB  = 12'b0000_0000_1000,
      S_FILL     = 12'b0000_0001_0000,
      S_RC_RD    = 12'b0000_0010_0000,
      S_RC_ADD   = 12'b0000_0100_0000,
      S_DIV_INIT = 12'b0000_1000_0000,
      S_DIV_STEP = 12'b0001_0000_0000,
      S_DIV_DONE = 12'b0010_0000_0000,
      S_LAST_RD  = 12'b0100_0000_0000,
      S_OUT      = 12'b1000_0000_0000
   } state_type;

   // control and model state
   state_type                  state_ff, state_in;
   logic [CSR_W-1:0]           win_ff, win_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]         total_ff, total_in;
   logic [DATA_W-1:0]          avg_ff, avg_in;
   logic [SLOT_W-1:0]          idx_ff, idx_in;
   logic [BIT_W-1:0]           bit_ff, bit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   // payload
   req_kind_type               op_ff, op_in;
   logic [DATA_W-1:0]          val_ff, val_in;
   logic                       neg_ff, neg_in;
   logic [TOTAL_W-1:0]         quot_ff, quot_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [39:0]                rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0]          rdata_ff;

   // ring memory
   logic [DATA_W-1:0]          ring_mem [MAX_SLOTS];
   logic                       mem_we;
   logic [SLOT_W-1:0]          mem_waddr;
   logic [DATA_W-1:0]          mem_wdata;
   logic [SLOT_W-1:0]          rd_addr;

   // shared unit
   logic [AW-1:0]              alu_a, alu_b, alu_res;
   logic                       alu_sub, alu_neg;

   // derived values
   logic [NW-1:0]              win_ext;
   logic [CNT_W-1:0]           wsize, wlast, divisor;
   logic [SLOT_W-1:0]          slot_eff, slot_next;
   logic [CNT_W-1:0]           slot_inc;
   logic [CNT_W:0]             div_shift;
   logic                       idx_last;

   rma_alu #(.WIDTH(AW)) u_alu (
      .opa      (alu_a),
      .opb      (alu_b),
      .sub      (alu_sub),
      .result   (alu_res),
      .negative (alu_neg)
   );

   always_comb begin
      win_ext = NW'(win_ff);
      if (win_ff == '0) begin
         wsize = CNT_W'(1);
      end else if (win_ext > NW'(MAX_SLOTS)) begin
         wsize = CNT_W'(MAX_SLOTS);
      end else begin
         wsize = win_ext[CNT_W-1:0];
      end
      wlast     = wsize - CNT_W'(1);
      divisor   = (cnt_ff == '0) ? CNT_W'(1) : cnt_ff;
      slot_eff  = (CNT_W'(slot_ff) >= wsize) ? '0 : slot_ff;
      slot_inc  = CNT_W'(slot_ff) + CNT_W'(1);
      slot_next = (slot_inc >= wsize) ? '0 : slot_inc[SLOT_W-1:0];
      div_shift = {rem_ff, quot_ff[TOTAL_W-1]};
      idx_last  = (CNT_W'(idx_ff) == wlast);
   end

   // operand selection for the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_REC_ADD, S_FILL: begin
            alu_a = {{(AW-TOTAL_W){total_ff[TOTAL_W-1]}}, total_ff};
            alu_b = {{(AW-DATA_W){val_ff[DATA_W-1]}}, val_ff};
         end
         S_REC_SUB: begin
            alu_a   = {{(AW-TOTAL_W){total_ff[TOTAL_W-1]}}, total_ff};
            alu_b   = {{(AW-DATA_W){rdata_ff[DATA_W-1]}}, rdata_ff};
            alu_sub = 1'b1;
         end
         S_RC_ADD: begin
            alu_a = {{(AW-TOTAL_W){total_ff[TOTAL_W-1]}}, total_ff};
            alu_b = {{(AW-DATA_W){rdata_ff[DATA_W-1]}}, rdata_ff};
         end
         S_DIV_INIT: begin
            alu_b   = {{(AW-TOTAL_W){total_ff[TOTAL_W-1]}}, total_ff};
            alu_sub = 1'b1;
         end
         S_DIV_STEP: begin
            alu_a   = AW'(div_shift);
            alu_b   = AW'(divisor);
            alu_sub = 1'b1;
         end
         S_DIV_DONE: begin
            alu_b   = AW'(quot_ff);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      avg_in       = avg_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = val_ff;
      rd_addr      = idx_ff;

      if (csr_valid) begin
         win_in = csr_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            idx_in    = idx_ff + SLOT_W'(1);
            if (idx_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_kind_type'(req_tuser);
               val_in = req_tdata;
               idx_in = '0;
               unique case (req_kind_type'(req_tuser))
                  REQ_RECORD: begin
                     slot_in  = slot_eff;
                     rd_addr  = slot_eff;
                     cnt_in   = (cnt_ff < wsize) ? cnt_ff + CNT_W'(1) : wsize;
                     state_in = S_REC_ADD;
                  end
                  REQ_RESET, REQ_FLUSH: begin
                     total_in = '0;
                     state_in = S_FILL;
                  end
                  REQ_RECALC: begin
                     total_in = '0;
                     state_in = S_RC_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_REC_ADD: begin
            rd_addr  = slot_ff;
            total_in = alu_res[TOTAL_W-1:0];
            state_in = S_REC_SUB;
         end
         S_REC_SUB: begin
            total_in  = alu_res[TOTAL_W-1:0];
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            slot_in   = slot_next;
            state_in  = S_DIV_INIT;
         end
         S_FILL: begin
            mem_we   = 1'b1;
            total_in = alu_res[TOTAL_W-1:0];
            idx_in   = idx_ff + SLOT_W'(1);
            if (idx_last) begin
               if (op_ff == REQ_FLUSH) begin
                  cnt_in = wsize;
                  avg_in = val_ff;
               end else begin
                  cnt_in = '0;
               end
               state_in = S_LAST_RD;
            end
         end
         S_RC_RD: begin
            state_in = S_RC_ADD;
         end
         S_RC_ADD: begin
            total_in = alu_res[TOTAL_W-1:0];
            idx_in   = idx_ff + SLOT_W'(1);
            state_in = idx_last ? S_DIV_INIT : S_RC_RD;
         end
         S_DIV_INIT: begin
            // divide the magnitude, restore the sign at the end
            neg_in   = total_ff[TOTAL_W-1];
            quot_in  = total_ff[TOTAL_W-1] ? alu_res[TOTAL_W-1:0] : total_ff;
            rem_in   = '0;
            bit_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            if (alu_neg) begin
               rem_in  = div_shift[CNT_W-1:0];
               quot_in = {quot_ff[TOTAL_W-2:0], 1'b0};
            end else begin
               rem_in  = alu_res[CNT_W-1:0];
               quot_in = {quot_ff[TOTAL_W-2:0], 1'b1};
            end
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(TOTAL_W - 1)) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            // saturate to the 16-bit range
            if (!neg_ff) begin
               avg_in = (quot_ff > TOTAL_W'(32767)) ? DATA_W'(32767)
                                                      : quot_ff[DATA_W-1:0];
            end else begin
               avg_in = (quot_ff > TOTAL_W'(32768)) ? DATA_W'(32768)
                                                      : alu_res[DATA_W-1:0];
            end
            state_in = S_LAST_RD;
         end
         S_LAST_RD: begin
            rd_addr  = (slot_ff == '0) ? wlast[SLOT_W-1:0] : slot_ff - SLOT_W'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {1'b0, CSR_W'(cnt_ff),
                               (cnt_ff == '0) ? DATA_W'(0) : rdata_ff, avg_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         win_ff       <= CSR_W'(WIN_RESET);
         slot_ff      <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         avg_ff       <= '0;
         idx_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         slot_ff      <= slot_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         avg_ff       <= avg_in;
         idx_ff       <= idx_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      neg_ff      <= neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= ring_mem[rd_addr];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_DONE) |-> (rem_ff < divisor))
      else $error("divider remainder not below divisor");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output load");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_W'(MAX_SLOTS)))
      else $error("sample count beyond ring depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready && !$stable(state_ff))
      else $error("request accepted without starting work");
`endif

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the ring moving-average filter against a cycle-free predictor. One
// request word goes in at a time and each response word is compared field by
// field with the oldest prediction. Directed cases cover fills, the window
// extremes and a window change without a reset fill. Random traffic follows,
// in phases that vary the window and the idle and stall pattern on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rma_pkg::*;

   localparam int SLOTS        = MAX_SLOTS_DEF;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 100;

   // packed from the top down: sample_count, last_value, average
   typedef struct packed {
      logic [CSR_W-1:0]  sample_count;
      logic [DATA_W-1:0] last_value;
      logic [DATA_W-1:0] average;
   } avg_word_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic [TYPE_W-1:0]   req_tuser  = REQ_RECORD;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_data   = '0;

   // filter state as the block should hold it
   logic signed [DATA_W-1:0] ring_copy [SLOTS];
   int unsigned              slot_ptr;
   int unsigned              held_count;
   longint                   total_sum;
   logic signed [DATA_W-1:0] held_avg;
   logic [CSR_W-1:0]         window_reg;

   avg_word_type pending_words [$];
   int           mismatch_count = 0;
   int           gap_pct        = 0;
   int           stall_pct      = 0;
   int unsigned  cycle_count    = 0;

   ring_moving_average #(
      .MAX_SLOTS (SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] sample_value
      .req_tuser  (req_tuser),   // [1:0] req_type
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] average, [31:16] last_value, [38:32] sample_count
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned active_slots();
      if (window_reg == 0) return 1;
      if (window_reg > SLOTS) return SLOTS;
      return window_reg;
   endfunction

   function automatic longint clamp_total(longint t);
      if (t > 64'sd2147483647) return 64'sd2147483647;
      if (t < -64'sd2147483648) return -64'sd2147483648;
      return t;
   endfunction

   function automatic logic signed [DATA_W-1:0] mean_of(longint t, int unsigned c);
      longint q;
      q = t / longint'((c == 0) ? 1 : c);
      if (q > 32767) return 16'sh7FFF;
      if (q < -32768) return 16'sh8000;
      return q[DATA_W-1:0];
   endfunction

   function automatic void fill_ring(logic signed [DATA_W-1:0] v, int unsigned n);
      for (int unsigned i = 0; i < n; i++) ring_copy[i] = v;
      total_sum = longint'(v) * longint'(n);
   endfunction

   function automatic avg_word_type advance_filter(req_kind_type kind,
                                                   logic [DATA_W-1:0] raw);
      logic signed [DATA_W-1:0] v;
      int unsigned              n;
      int unsigned              idx;
      longint                   acc;
      avg_word_type             word;
      v = raw;
      n = active_slots();
      case (kind)
         REQ_RECORD: begin
            if (slot_ptr >= n) slot_ptr = 0;
            if (held_count < n) held_count++;
            else held_count = n;
            total_sum = clamp_total(total_sum + longint'(v) - longint'(ring_copy[slot_ptr]));
            ring_copy[slot_ptr] = v;
            slot_ptr++;
            if (slot_ptr >= n) slot_ptr = 0;
            held_avg = mean_of(total_sum, held_count);
         end
         REQ_RESET: begin
            fill_ring(v, n);
            held_count = 0;
         end
         REQ_FLUSH: begin
            fill_ring(v, n);
            held_count = n;
            held_avg = v;
         end
         default: begin
            acc = 0;
            for (int unsigned i = 0; i < n; i++) acc += longint'(ring_copy[i]);
            total_sum = clamp_total(acc);
            held_avg = mean_of(total_sum, held_count);
         end
      endcase
      word.average = held_avg;
      word.last_value = '0;
      if (held_count != 0) begin
         idx = (slot_ptr == 0) ? (n - 1) : (slot_ptr - 1);
         if (idx >= SLOTS) idx = SLOTS - 1;
         word.last_value = ring_copy[idx];
      end
      word.sample_count = held_count[CSR_W-1:0];
      return word;
   endfunction

   // ------------------------------------------------------------------------
   // response check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      avg_word_type got;
      avg_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[38:0];
         if (pending_words.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_words.pop_front();
            if (got.average !== want.average) begin
               $error("average: expected %0d, got %0d",
                      $signed(want.average), $signed(got.average));
               mismatch_count++;
            end
            if (got.last_value !== want.last_value) begin
               $error("last_value: expected %0d, got %0d",
                      $signed(want.last_value), $signed(got.last_value));
               mismatch_count++;
            end
            if (got.sample_count !== want.sample_count) begin
               $error("sample_count: expected %0d, got %0d",
                      want.sample_count, got.sample_count);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers; every task starts and ends in the time step of a rising edge
   // ------------------------------------------------------------------------
   task automatic send_word(req_kind_type kind, logic [DATA_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pending_words.push_back(advance_filter(kind, value));
      // keep valid high for back-to-back words unless a gap follows
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   task automatic write_window(logic [CSR_W-1:0] slots);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= slots;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_reg = slots;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 48; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 48; end
         default: begin gap_pct = 33; stall_pct = 33; end
      endcase
   endtask

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3))
                                     : 16'h8000 + 16'($urandom_range(3));
         1: return 16'($urandom_range(16)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_kind_type pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return REQ_RECORD;
      if (roll < 78) return REQ_RESET;
      if (roll < 86) return REQ_FLUSH;
      return REQ_RECALC;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_fill_and_record();
      // recalculate with nothing counted divides by one
      send_word(REQ_RECALC, 16'h0000);
      send_word(REQ_RECORD, 16'h7FFF);
      send_word(REQ_RECORD, 16'h8000);
      send_word(REQ_RECORD, 16'h8000);
      send_word(REQ_RECORD, 16'h0001);
      send_word(REQ_RECORD, 16'h7FFF);   // overwrites slot 0 after the slot index wraps
      send_word(REQ_RESET, 16'hFB2E);
      send_word(REQ_RECORD, 16'h0005);
      send_word(REQ_FLUSH, 16'h7FFF);
      send_word(REQ_FLUSH, 16'h8000);
      send_word(REQ_RECALC, 16'hFFFF);
   endtask

   task automatic test_window_extremes();
      write_window(7'd1);
      send_word(REQ_RECORD, 16'h1234);
      send_word(REQ_RECORD, 16'hFFFF);
      send_word(REQ_RECALC, 16'h0000);
      write_window(7'd0);                // acts as one slot
      send_word(REQ_RECORD, 16'h8000);
      send_word(REQ_RESET, 16'h0042);
      write_window(7'd127);              // clamps to the full ring
      send_word(REQ_FLUSH, 16'h7FFF);
      send_word(REQ_RECORD, 16'h8000);
      send_word(REQ_RECALC, 16'h0000);
   endtask

   task automatic test_window_shrink_stale();
      // shrink with a full stale total: count drops and the average saturates
      write_window(7'd1);
      send_word(REQ_RECORD, 16'h7FFF);
      write_window(7'd3);
      send_word(REQ_RECORD, 16'h0010);
      send_word(REQ_RECALC, 16'h0000);
      send_word(REQ_RESET, 16'h8001);
   endtask

   task automatic test_random_traffic();
      logic [CSR_W-1:0] windows [12] = '{7'd4, 7'd1, 7'd64, 7'd2, 7'd7, 7'd0,
                                         7'd33, 7'd127, 7'd16, 7'd3, 7'd64, 7'd5};
      for (int p = 0; p < 12; p++) begin
         write_window(windows[p]);
         set_idling(p % 4);
         // at random, about half the phases keep the stale ring to exercise a change without fill
         if ($urandom_range(1)) send_word($urandom_range(1) ? REQ_FLUSH : REQ_RESET,
                                          pick_sample());
         repeat (PHASE_ITEMS) send_word(pick_kind(), pick_sample());
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) ring_copy[i] = '0;
      slot_ptr   = 0;
      held_count = 0;
      total_sum  = 0;
      held_avg   = '0;
      window_reg = WIN_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_fill_and_record();
      test_window_extremes();
      test_window_shrink_stale();
      test_random_traffic();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
